### sv/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam logic [7:0] ESC_BYTE = 8'h1B;
  localparam logic [7:0] TAB_BYTE = 8'h09;
  localparam logic [7:0] NL_BYTE  = 8'h0A;
  localparam logic [7:0] CR_BYTE  = 8'h0D;
  localparam logic [7:0] SPACE_BYTE = 8'h20;

  localparam logic [1:0] REG_ATTRIBUTE  = 2'd0;
  localparam logic [1:0] REG_TAB_WIDTH  = 2'd1;
  localparam logic [1:0] REG_ESCAPE_END = 2'd2;

  localparam logic [7:0] ATTRIBUTE_RST  = 8'd3;
  localparam logic [4:0] TAB_WIDTH_RST  = 5'd4;
  localparam logic [7:0] ESCAPE_END_RST = 8'd109;

  typedef enum logic [2:0] {
    OP_READ,
    OP_PRINT,
    OP_NEWLINE,
    OP_CR,
    OP_TAB
  } tcw_op_e;

  typedef struct packed {
    tcw_op_e     op;
    logic [7:0]  ch;
    logic [10:0] cidx;
  } tcw_item_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic      valid;
    tcw_item_t item;
  } tcw_head_t;

  typedef struct packed {
    logic [7:0] attribute;
    logic [4:0] tab_width;
    logic [7:0] escape_end;
  } tcw_cfg_t;

endpackage

### sv/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front
// Accepts items, swallows escape sequences, classifies bytes into ops and
// holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module tcw_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tcw_pkg::tcw_cfg_t cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              cmd_i,
  input  logic [7:0]        char_code_i,
  input  logic [10:0]       cell_index_i,
  output tcw_pkg::tcw_head_t head_o,
  input  logic              pop_i
);
  import tcw_pkg::*;

  tcw_item_t   q_mem [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        esc_q;
  logic        accept, push;
  tcw_item_t   item_c;

  assign in_ready_o = (cnt_q != 2'd2);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    item_c.ch   = char_code_i;
    item_c.cidx = cell_index_i;
    push        = 1'b0;
    if (cmd_i) begin
      item_c.op = OP_READ;
      push      = 1'b1;
    end else begin
      unique case (char_code_i)
        TAB_BYTE: item_c.op = OP_TAB;
        NL_BYTE:  item_c.op = OP_NEWLINE;
        CR_BYTE:  item_c.op = OP_CR;
        default:  item_c.op = OP_PRINT;
      endcase
      push = !esc_q && (char_code_i != ESC_BYTE);
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
      esc_q    <= 1'b0;
    end else begin
      if (accept && !cmd_i) begin
        if (esc_q) esc_q <= (char_code_i != cfg_i.escape_end);
        else if (char_code_i == ESC_BYTE) esc_q <= 1'b1;
      end
      if (accept && push) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, accept && push} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && push) q_mem[wr_ptr_q] <= item_c;
  end

endmodule

### sv/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back
// Executes queued ops against the cell memory: cursor, wrap, scroll copy,
// tab expansion, cell reads and the result register.
// ----------------------------------------------------------------------------
module tcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tcw_pkg::tcw_cfg_t  cfg_i,
  input  tcw_pkg::tcw_head_t head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [10:0]        cursor_pos_o,
  output logic [15:0]        read_data_o,
  output logic               scrolled_o,
  output logic               is_read_o
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int LAST  = (ROWS - 1) * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS + 1);
  localparam int BW    = $clog2(CW);
  localparam int RW    = $clog2(ROWS);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_ACT, S_RDOUT, S_MOD, S_TCHK, S_TPUT, S_SCROLL
  } state_e;

  state_e        state_q;
  logic [15:0]   mem [CELLS];
  logic [15:0]   rdata_q;
  logic [AW-1:0] w_q;
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  tcw_op_e       op_q;
  logic [7:0]    ch_q;
  logic          rd_ok_q, ret_q, scr_q;
  logic [BW-1:0] bit_q;
  logic [4:0]    rem_q, cnt_q;
  logic          out_valid_q, scrolled_q, is_read_q;
  logic [10:0]   pos_q;
  logic [15:0]   rd_out_q;

  logic          can_emit, col_full, bottom, wrap_c, in_range, last_sp;
  logic [4:0]    tw_eff;
  logic [5:0]    rem_sh;
  logic [4:0]    rem_nx;
  logic [10:0]   pos_c, pos_inc_c;
  logic [AW-1:0] addr_c;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata;
  int            nxt_rd;

  assign can_emit  = !out_valid_q || out_ready_i;
  assign col_full  = int'(col_q) >= COLUMNS;
  assign bottom    = int'(row_q) == ROWS - 1;
  assign wrap_c    = (head_i.item.op == OP_NEWLINE) || col_full;
  assign in_range  = int'(head_i.item.cidx) < CELLS;
  assign last_sp   = (cnt_q == 5'd1);
  assign tw_eff    = (cfg_i.tab_width == 5'd0) ? 5'd1 : cfg_i.tab_width;
  assign rem_sh    = {rem_q, col_q[bit_q]};
  assign rem_nx    = (rem_sh >= {1'b0, tw_eff}) ? 5'(rem_sh - {1'b0, tw_eff})
                                                : rem_sh[4:0];
  assign pos_c     = 11'(int'(row_q) * COLUMNS + int'(col_q));
  assign pos_inc_c = 11'(int'(row_q) * COLUMNS + int'(col_q) + 1);
  assign addr_c    = AW'(int'(row_q) * COLUMNS + int'(col_q));
  assign nxt_rd    = int'(w_q) + 1 + COLUMNS;
  assign pop_o     = (state_q == S_IDLE) && head_i.valid;

  // memory port control
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = addr_c;
    raddr = AW'(COLUMNS);
    wdata = '0;
    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = w_q;
      end
      S_IDLE: begin
        if (head_i.valid) begin
          if (head_i.item.op == OP_READ) begin
            re    = in_range;
            raddr = AW'(head_i.item.cidx);
          end else begin
            re = wrap_c && bottom;
          end
        end
      end
      S_TCHK: re = col_full && bottom;
      S_SCROLL: begin
        we    = 1'b1;
        waddr = w_q;
        wdata = (int'(w_q) < LAST) ? rdata_q : 16'h0000;
        re    = nxt_rd < CELLS;
        raddr = AW'(nxt_rd);
      end
      S_ACT: begin
        we    = (op_q == OP_PRINT) && can_emit;
        wdata = {cfg_i.attribute, ch_q};
      end
      S_TPUT: begin
        we    = !last_sp || can_emit;
        wdata = {cfg_i.attribute, SPACE_BYTE};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      w_q         <= '0;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
      scrolled_q  <= 1'b0;
      scr_q       <= 1'b0;
      is_read_q   <= 1'b0;
      ret_q       <= 1'b0;
      op_q        <= OP_PRINT;
      ch_q        <= '0;
      rd_ok_q     <= 1'b0;
      bit_q       <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      pos_q       <= '0;
      rd_out_q    <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          w_q <= w_q + 1'b1;
          if (w_q == AW'(CELLS - 1)) begin
            w_q     <= '0;
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (head_i.valid) begin
            op_q  <= head_i.item.op;
            ch_q  <= head_i.item.ch;
            scr_q <= 1'b0;
            if (head_i.item.op == OP_READ) begin
              rd_ok_q <= in_range;
              state_q <= S_RDOUT;
            end else if (wrap_c) begin
              col_q <= '0;
              if (bottom) begin
                scr_q   <= 1'b1;
                w_q     <= '0;
                ret_q   <= 1'b0;
                state_q <= S_SCROLL;
              end else begin
                row_q   <= row_q + 1'b1;
                state_q <= S_ACT;
              end
            end else begin
              state_q <= S_ACT;
            end
          end
        end
        S_ACT: begin
          unique case (op_q)
            OP_TAB: begin
              bit_q   <= BW'(CW - 1);
              rem_q   <= '0;
              state_q <= S_MOD;
            end
            OP_PRINT: begin
              if (can_emit) begin
                col_q       <= col_q + 1'b1;
                out_valid_q <= 1'b1;
                pos_q       <= pos_inc_c;
                rd_out_q    <= '0;
                scrolled_q  <= scr_q;
                is_read_q   <= 1'b0;
                state_q     <= S_IDLE;
              end
            end
            default: begin
              if (can_emit) begin
                out_valid_q <= 1'b1;
                pos_q       <= pos_c;
                rd_out_q    <= '0;
                scrolled_q  <= scr_q;
                is_read_q   <= 1'b0;
                state_q     <= S_IDLE;
              end
            end
          endcase
        end
        S_MOD: begin
          // restoring remainder, one column bit a cycle
          rem_q <= rem_nx;
          if (bit_q == '0) begin
            cnt_q   <= tw_eff - rem_nx;
            state_q <= S_TCHK;
          end else begin
            bit_q <= bit_q - 1'b1;
          end
        end
        S_TCHK: begin
          if (col_full) begin
            col_q <= '0;
            if (bottom) begin
              scr_q   <= 1'b1;
              w_q     <= '0;
              ret_q   <= 1'b1;
              state_q <= S_SCROLL;
            end else begin
              row_q   <= row_q + 1'b1;
              state_q <= S_TPUT;
            end
          end else begin
            state_q <= S_TPUT;
          end
        end
        S_TPUT: begin
          if (!last_sp) begin
            col_q   <= col_q + 1'b1;
            cnt_q   <= cnt_q - 1'b1;
            state_q <= S_TCHK;
          end else if (can_emit) begin
            col_q       <= col_q + 1'b1;
            out_valid_q <= 1'b1;
            pos_q       <= pos_inc_c;
            rd_out_q    <= '0;
            scrolled_q  <= scr_q;
            is_read_q   <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        S_SCROLL: begin
          w_q <= w_q + 1'b1;
          if (w_q == AW'(CELLS - 1)) begin
            w_q     <= '0;
            state_q <= ret_q ? S_TPUT : S_ACT;
          end
        end
        S_RDOUT: begin
          if (can_emit) begin
            out_valid_q <= 1'b1;
            pos_q       <= pos_c;
            rd_out_q    <= rd_ok_q ? rdata_q : 16'h0000;
            scrolled_q  <= 1'b0;
            is_read_q   <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cursor_pos_o = pos_q;
  assign read_data_o  = rd_out_q;
  assign scrolled_o   = scrolled_q;
  assign is_read_o    = is_read_q;

endmodule

### sv/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Text console engine over a ROWS x COLUMNS cell memory.
// ----------------------------------------------------------------------------
// Reset: control clears at once. The cell memory is then zeroed by a sweep over
//   all ROWS*COLUMNS cells (2000 by default). Up to two transfers queue meanwhile.
// Print, newline, CR, read: popped in S_IDLE, result registered in S_ACT (S_RDOUT
//   for a read) once the result slot is free; one item in the back end at a time.
// Tab: S_MOD forms the bit-serial remainder over $clog2(COLUMNS+1) column bits,
//   then S_TCHK/S_TPUT per space. Scroll: a sweep over all cells copies rows up.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [7:0]  char_code_i,
  input  logic [10:0] cell_index_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [10:0] cursor_pos_o,
  output logic [15:0] read_data_o,
  output logic        scrolled_o,
  output logic        is_read_o
);
  import tcw_pkg::*;

  tcw_cfg_t  cfg_q;
  tcw_head_t head;
  logic      pop;

  // Config registers; unused index is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attribute  <= ATTRIBUTE_RST;
      cfg_q.tab_width  <= TAB_WIDTH_RST;
      cfg_q.escape_end <= ESCAPE_END_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ATTRIBUTE:  cfg_q.attribute  <= cfg_wdata_i;
        REG_TAB_WIDTH:  cfg_q.tab_width  <= cfg_wdata_i[4:0];
        REG_ESCAPE_END: cfg_q.escape_end <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // front: escape filter, op classification, two-entry queue; queued items
  // simply wait while the back end runs its clear sweep
  tcw_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_i        (cfg_q),
    .in_valid_i,
    .in_ready_o,
    .cmd_i,
    .char_code_i,
    .cell_index_i,
    .head_o       (head),
    .pop_i        (pop)
  );

  // back: cursor, memory, scroll, tab expansion, result register
  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cfg_i        (cfg_q),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o,
    .out_ready_i,
    .cursor_pos_o,
    .read_data_o,
    .scrolled_o,
    .is_read_o
  );

endmodule

### sv/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [10:0] cursor_pos_o,
  input logic [15:0] read_data_o,
  input logic        scrolled_o,
  input logic        is_read_o
);

  localparam int CELLS = ROWS * COLUMNS;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cursor_pos_o) &&
    $stable(read_data_o) && $stable(scrolled_o) && $stable(is_read_o))
    else $error("stalled result dropped or changed");

  a_put_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_read_o |-> read_data_o == 16'h0000)
    else $error("put result carries read data");

  a_read_no_scroll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_read_o |-> !scrolled_o)
    else $error("read result flags a scroll");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(cursor_pos_o) <= CELLS) || (CELLS > 2047))
    else $error("cursor position beyond the screen");

endmodule

bind text_console_writer tcw_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_tcw_checker (.*);

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks text_console_writer against an internal console predictor. Puts and
// reads go in under random gaps on both handshakes. Each transfer out is
// compared field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module testbench;
  import tcw_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  typedef struct {
    logic [10:0] cursor_pos;
    logic [15:0] read_data;
    logic        scrolled;
    logic        is_read;
  } console_result_t;

  // Console predictor plus the queue of results it has promised.
  class console_scoreboard;
    logic [15:0]     cells [CELLS];
    int unsigned     col, row;
    bit              in_esc;
    logic [7:0]      attr, esc_end;
    logic [4:0]      tab_w;
    console_result_t pending_q[$];
    int              errors, scrolls_seen, reads_seen, puts_seen;

    function void clear();
      foreach (cells[i]) cells[i] = '0;
      col = 0;
      row = 0;
      in_esc = 0;
      attr = ATTRIBUTE_RST;
      tab_w = TAB_WIDTH_RST;
      esc_end = ESCAPE_END_RST;
    endfunction

    function bit advance_line(bit nl);
      if (nl || col >= COLUMNS) begin
        col = 0;
        row++;
      end
      if (row >= ROWS) begin
        for (int i = 0; i < CELLS - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++) cells[i] = '0;
        row = ROWS - 1;
        return 1;
      end
      return 0;
    endfunction

    function void store(logic [7:0] b);
      int unsigned a;
      a = row * COLUMNS + col;
      if (a < CELLS) cells[a] = {attr, b};
      col++;
    endfunction

    // Note an accepted input; returns 1 when it produces a result.
    function bit note_input(logic c, logic [7:0] ch, logic [10:0] ix);
      console_result_t r;
      int unsigned tw, n;
      bit scr;
      scr = 0;
      r.read_data = '0;
      if (c) begin
        r.cursor_pos = 11'(row * COLUMNS + col);
        r.read_data = (ix < CELLS) ? cells[ix] : 16'h0;
        r.scrolled = 0;
        r.is_read = 1;
        pending_q.push_back(r);
        return 1;
      end
      if (in_esc) begin
        in_esc = (ch != esc_end);
        return 0;
      end
      if (ch == ESC_BYTE) begin
        in_esc = 1;
        return 0;
      end
      scr = advance_line(ch == NL_BYTE);
      if (ch == TAB_BYTE) begin
        tw = (tab_w == 0) ? 1 : tab_w;
        n = tw - (col % tw);
        repeat (n) begin
          scr |= advance_line(0);
          store(SPACE_BYTE);
        end
      end else if (ch != NL_BYTE && ch != CR_BYTE) begin
        store(ch);
      end
      r.cursor_pos = 11'(row * COLUMNS + col);
      r.scrolled = scr;
      r.is_read = 0;
      pending_q.push_back(r);
      return 1;
    endfunction

    function void check(console_result_t act);
      console_result_t e;
      if (pending_q.size() == 0) begin
        $error("result transfer with nothing expected (cursor_pos %0d)", act.cursor_pos);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (act.is_read) reads_seen++;
      else puts_seen++;
      if (act.scrolled) scrolls_seen++;
      if (act.cursor_pos !== e.cursor_pos) begin
        $error("cursor_pos expected %0d got %0d", e.cursor_pos, act.cursor_pos);
        errors++;
      end
      if (act.read_data !== e.read_data) begin
        $error("read_data expected %h got %h", e.read_data, act.read_data);
        errors++;
      end
      if (act.scrolled !== e.scrolled) begin
        $error("scrolled expected %0d got %0d", e.scrolled, act.scrolled);
        errors++;
      end
      if (act.is_read !== e.is_read) begin
        $error("is_read expected %0d got %0d", e.is_read, act.is_read);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [7:0]  cfg_wdata_i;
  logic        in_valid_i, in_ready_o, cmd_i;
  logic [7:0]  char_code_i;
  logic [10:0] cell_index_i;
  logic        out_valid_o, out_ready_i;
  logic [10:0] cursor_pos_o;
  logic [15:0] read_data_o;
  logic        scrolled_o, is_read_o;

  console_scoreboard sb;
  int unsigned       live_items, swallowed;

  text_console_writer #(.COLUMNS(COLUMNS), .ROWS(ROWS)) dut (.*);

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop: far above the slowest legal run (every item a scroll sweep over
  // all CELLS cells plus the longest stalls).
  initial begin
    #60000000;
    $display("FAIL text_console_writer");
    $finish;
  end

  // Sink side: ready drops at random, mostly briefly, sometimes for long
  // stretches, and some bursts keep it high throughout.
  initial begin
    int mode;
    out_ready_i = 0;
    forever begin
      mode = $urandom_range(0, 99);
      @(posedge clk_i);
      if (mode < 30) begin
        out_ready_i <= 1;
        repeat ($urandom_range(20, 200)) @(posedge clk_i);
      end else if (mode < 90) begin
        out_ready_i <= 1'($urandom_range(0, 1));
      end else begin
        out_ready_i <= 0;
        repeat ($urandom_range(10, 50)) @(posedge clk_i);
      end
    end
  end

  // Result monitor; samples the pre-edge values.
  always @(posedge clk_i) begin
    console_result_t act;
    if (rst_ni && out_valid_o && out_ready_i) begin
      act.cursor_pos = cursor_pos_o;
      act.read_data = read_data_o;
      act.scrolled = scrolled_o;
      act.is_read = is_read_o;
      sb.check(act);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // One input transfer; always returns at the accepting edge.
  task automatic send_item(input logic c, input logic [7:0] ch, input logic [10:0] ix);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    cmd_i <= c;
    char_code_i <= ch;
    cell_index_i <= ix;
    do @(posedge clk_i); while (!in_ready_o);
    if (sb.note_input(c, ch, ix)) live_items++;
    else swallowed++;
  endtask

  task automatic put(input logic [7:0] ch);
    send_item(1'b0, ch, 11'($urandom_range(0, 2047)));
  endtask

  task automatic peek(input logic [10:0] ix);
    send_item(1'b1, 8'($urandom_range(0, 255)), ix);
  endtask

  // Let every promised result arrive, then a margin for swallowed bytes
  // still in flight. Registers are only touched after this.
  task automatic settle();
    in_valid_i <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [7:0] a, input logic [4:0] t, input logic [7:0] e);
    cfg_we_i <= 1;
    cfg_idx_i <= REG_ATTRIBUTE;
    cfg_wdata_i <= a;
    @(posedge clk_i);
    cfg_idx_i <= REG_TAB_WIDTH;
    cfg_wdata_i <= {3'b0, t};
    @(posedge clk_i);
    cfg_idx_i <= REG_ESCAPE_END;
    cfg_wdata_i <= e;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.attr = a;
    sb.tab_w = t;
    sb.esc_end = e;
  endtask

  // Random traffic: mostly text with well-formed escape sequences, some
  // reads, and raw bytes as noise.
  task automatic random_traffic(input int unsigned count);
    int r;
    int unsigned target;
    target = live_items + count;
    while (live_items < target) begin
      r = $urandom_range(0, 99);
      if (sb.in_esc) begin
        if (r < 60) put(8'($urandom_range(8'h30, 8'h3B)));
        else if (r < 90) put(sb.esc_end);
        else put(8'($urandom_range(0, 255)));
      end else if (r < 35) begin
        if ($urandom_range(0, 19) == 0) peek(11'($urandom_range(CELLS, 2047)));
        else peek(11'($urandom_range(0, CELLS - 1)));
      end else if (r < 70) put(8'($urandom_range(8'h20, 8'h7E)));
      else if (r < 74) put(TAB_BYTE);
      else if (r < 77) put(NL_BYTE);
      else if (r < 79) put(CR_BYTE);
      else if (r < 83) put(ESC_BYTE);
      else put(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_idx_i = REG_ATTRIBUTE;
    cfg_wdata_i = '0;
    in_valid_i = 0;
    cmd_i = 0;
    char_code_i = '0;
    cell_index_i = '0;
    live_items = 0;
    swallowed = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: reset defaults, byte extremes, every control byte, escapes,
    // reads at both ends of the screen and past it.
    put(8'h41);
    put(8'h00);
    put(8'hFF);
    put(TAB_BYTE);
    put(TAB_BYTE);
    put(CR_BYTE);
    put(NL_BYTE);
    put(ESC_BYTE);
    put(8'h5B);
    put(8'h31);
    put(8'h6D);
    put(ESC_BYTE);
    put(ESC_BYTE);
    put(ESCAPE_END_RST);
    peek(11'd0);
    peek(11'd2);
    peek(11'(CELLS - 1));
    peek(11'(CELLS));
    peek(11'd2047);
    settle();

    // Phases with register extremes: tab width zero and its maximum of 31,
    // escape end at zero, 255 and ESC itself.
    set_config(8'h00, 5'd0, 8'h00);
    random_traffic(300);
    settle();
    set_config(8'hFF, 5'd31, 8'hFF);
    for (int i = 0; i < 5; i++) put(TAB_BYTE);
    random_traffic(300);
    settle();
    set_config(8'hA5, 5'd1, ESCAPE_END_RST);
    random_traffic(300);
    settle();
    set_config(8'h5A, 5'd16, ESC_BYTE);
    random_traffic(300);
    settle();
    set_config(8'($urandom_range(0, 255)), 5'($urandom_range(1, 16)),
               8'($urandom_range(0, 255)));
    random_traffic(300);
    settle();
    set_config(ATTRIBUTE_RST, TAB_WIDTH_RST, ESCAPE_END_RST);
    random_traffic(300);

    in_valid_i <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("covered %0d puts, %0d reads, %0d scrolls, %0d swallowed bytes",
             sb.puts_seen, sb.reads_seen, sb.scrolls_seen, swallowed);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("PASS text_console_writer");
    end else begin
      $display("FAIL text_console_writer");
    end
    $finish;
  end

endmodule
